// ===== sv/fbmgn_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fbmgn_pkg
// Shared types, constants and arithmetic helpers of the fractal noise height
// evaluator.
// ----------------------------------------------------------------------------
package fbmgn_pkg;

  // Field widths
  localparam int unsigned IDX_W   = 10;
  localparam int unsigned GRAD_W  = 16;
  localparam int unsigned COORD_W = 27;
  localparam int unsigned H_W     = 16;
  localparam int unsigned CLS_W   = 3;
  localparam int unsigned CFG_IW  = 2;
  localparam int unsigned OCT_W   = 3;   // octave counter, up to eight octaves
  localparam int unsigned DOT_W   = 34;  // corner dot product, Q.31
  localparam int unsigned FADE_W  = 17;  // fade weight, Q0.16 up to 1.0

  // Gradient table depth; the corner index wraps at this power of two.
  localparam int unsigned TABLE_ENTRIES = 1024;

  // Item opcodes
  typedef enum logic {
    OP_LOAD = 1'b0,
    OP_EVAL = 1'b1
  } op_e;

  // Configuration register indexes
  typedef enum logic [CFG_IW-1:0] {
    REG_WATER = 2'd0,
    REG_SAND  = 2'd1,
    REG_GRASS = 2'd2,
    REG_ROCK  = 2'd3
  } cfg_reg_e;

  // Terrain classes
  typedef enum logic [CLS_W-1:0] {
    CLS_WATER = 3'd0,
    CLS_SAND  = 3'd1,
    CLS_GRASS = 3'd2,
    CLS_ROCK  = 3'd3,
    CLS_SNOW  = 3'd4
  } cls_e;

  // Octave amplitudes, 0.6^i in Q.16
  localparam logic [16:0] AMP_Q16 [8] = '{
    17'd65536, 17'd39322, 17'd23593, 17'd14156,
    17'd8493,  17'd5096,  17'd3058,  17'd1835
  };

  // One queued item as classified by the front end
  typedef struct packed {
    op_e                        op;
    logic [IDX_W-1:0]           entry_index;
    logic signed [GRAD_W-1:0]   grad_x;
    logic signed [GRAD_W-1:0]   grad_y;
    logic signed [COORD_W-1:0]  coord_x;
    logic signed [COORD_W-1:0]  coord_y;
  } item_t;

  // Classification thresholds
  typedef struct packed {
    logic signed [H_W-1:0] water;
    logic signed [H_W-1:0] sand;
    logic signed [H_W-1:0] grass;
    logic signed [H_W-1:0] rock;
  } thresh_t;

  // Status of the back end
  typedef struct packed {
    logic             busy;
    logic [OCT_W-1:0] octave;
  } bk_status_t;

  // Sum of the amplitudes of the first n octaves
  function automatic longint amp_sum(input int n);
    longint s;
    s = 0;
    for (int i = 0; i < 8; i++) begin
      if (i < n) s = s + longint'(AMP_Q16[i]);
    end
    return s;
  endfunction

  // Fade weight round((3 t^2 2^16 - 2 t^3) / 2^32) from t and t^2
  function automatic logic [FADE_W-1:0] fade(input logic [31:0] t2, input logic [15:0] t);
    logic [51:0] v;
    logic [47:0] t3;
    t3 = 48'(t2) * 48'(t);
    v  = 52'({t2, 16'd0}) * 52'd3 - {3'd0, t3, 1'b0} + 52'h0_0000_8000_0000;
    return v[48:32];
  endfunction

  // a + round(s * (b - a) / 2^16)
  function automatic logic signed [DOT_W-1:0] lerp(input logic signed [DOT_W-1:0] a,
                                                   input logic signed [DOT_W-1:0] b,
                                                   input logic [FADE_W-1:0] s);
    logic signed [DOT_W:0]      diff;
    logic signed [DOT_W+18:0]   prod;
    logic signed [DOT_W+18:0]   rnd;
    diff = (DOT_W+1)'(b) - (DOT_W+1)'(a);
    prod = (DOT_W+19)'($signed({1'b0, s})) * (DOT_W+19)'(diff);
    rnd  = (prod + (DOT_W+19)'(32768)) >>> 16;
    return a + DOT_W'(rnd);
  endfunction

endpackage

// ===== sv/fbmgn_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fbmgn_in_if / fbmgn_out_if
// Valid/ready channels for input items and result items.
// ----------------------------------------------------------------------------
interface fbmgn_in_if;
  logic        valid;
  logic        ready;
  logic        opcode;
  logic [9:0]  entry_index;
  logic [15:0] grad_x;
  logic [15:0] grad_y;
  logic [26:0] coord_x;
  logic [26:0] coord_y;

  modport source (output valid, opcode, entry_index, grad_x, grad_y, coord_x, coord_y,
                  input ready);
  modport sink   (input valid, opcode, entry_index, grad_x, grad_y, coord_x, coord_y,
                  output ready);
endinterface

interface fbmgn_out_if;
  logic        valid;
  logic        ready;
  logic [15:0] height;
  logic [2:0]  terrain_class;

  modport source (output valid, height, terrain_class, input ready);
  modport sink   (input valid, height, terrain_class, output ready);
endinterface

// ===== sv/fbmgn_front.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fbmgn_front
// Accepts input items, classifies them as load or evaluate and holds them in
// a two-entry queue for the back end.
// ----------------------------------------------------------------------------
module fbmgn_front (
  input  logic                clk_i,
  input  logic                rst_ni,
  fbmgn_in_if.sink            in_i,
  output logic                q_valid_o,
  output fbmgn_pkg::item_t    q_item_o,
  input  logic                q_pop_i
);
  import fbmgn_pkg::*;

  item_t      store_q [2];
  logic       wr_ptr_q, wr_ptr_d;
  logic       rd_ptr_q, rd_ptr_d;
  logic [1:0] count_q, count_d;
  logic       push;
  logic       pop;
  item_t      new_item;

  // Classify the incoming item.
  always_comb begin
    new_item.op          = in_i.opcode ? OP_EVAL : OP_LOAD;
    new_item.entry_index = in_i.entry_index;
    new_item.grad_x      = in_i.grad_x;
    new_item.grad_y      = in_i.grad_y;
    new_item.coord_x     = in_i.coord_x;
    new_item.coord_y     = in_i.coord_y;
  end

  assign in_i.ready = (count_q != 2'd2);
  assign push       = in_i.valid && in_i.ready;
  assign pop        = q_pop_i && (count_q != 2'd0);
  assign q_valid_o  = (count_q != 2'd0);
  assign q_item_o   = store_q[rd_ptr_q];

  // Queue pointers and fill count.
  always_comb begin
    wr_ptr_d = push ? ~wr_ptr_q : wr_ptr_q;
    rd_ptr_d = pop ? ~rd_ptr_q : rd_ptr_q;
    count_d  = count_q + 2'(push) - 2'(pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // Queue storage.
  always_ff @(posedge clk_i) begin
    if (push) store_q[wr_ptr_q] <= new_item;
  end

endmodule

// ===== sv/fbmgn_back.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fbmgn_back
// Executes queued items: writes the gradient table for load items and runs
// the octave sequencer, normalization and classing for evaluate items.
// ----------------------------------------------------------------------------
module fbmgn_back #(
  parameter int unsigned OCTAVES       = 6
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    q_valid_i,
  input  fbmgn_pkg::item_t        q_item_i,
  output logic                    q_pop_o,
  input  fbmgn_pkg::thresh_t      thresh_i,
  output fbmgn_pkg::bk_status_t   status_o,
  fbmgn_out_if.source             out_o
);
  import fbmgn_pkg::*;

  localparam int unsigned AW       = $clog2(TABLE_ENTRIES);
  localparam int unsigned PX_W     = COORD_W + 7;
  localparam int unsigned TOT_W    = 52;
  localparam int unsigned T31_W    = 36;
  localparam int unsigned PROD_W   = 62;
  localparam longint      AMP_SUM  = amp_sum(OCTAVES);
  localparam longint      RECIP    = ((64'sd1 <<< 40) + AMP_SUM / 2) / AMP_SUM;
  localparam logic signed [25:0] RECIP_C = 26'(RECIP);
  localparam logic [OCT_W-1:0]   LAST_OCT = OCT_W'(OCTAVES - 1);

  typedef enum logic [7:0] {
    S_IDLE  = 8'b0000_0001,
    S_CELL  = 8'b0000_0010,
    S_READ  = 8'b0000_0100,
    S_LERPX = 8'b0000_1000,
    S_LERPY = 8'b0001_0000,
    S_ACCUM = 8'b0010_0000,
    S_NORM  = 8'b0100_0000,
    S_EMIT  = 8'b1000_0000
  } state_e;

  state_e                       state_q, state_d;
  logic [OCT_W-1:0]             oct_q, oct_d;
  logic [2:0]                   k_q, k_d;
  logic                         out_valid_q, out_valid_d;

  logic signed [COORD_W-1:0]    x_q, y_q;
  logic [15:0]                  tx_q, ty_q;
  logic [31:0]                  t2x_q, t2y_q;
  logic [FADE_W-1:0]            sx_q, sy_q;
  logic [AW-1:0]                base_q;
  logic signed [DOT_W-1:0]      d_q [4];
  logic signed [DOT_W-1:0]      i1_q, i2_q, n_q;
  logic signed [TOT_W-1:0]      total_q;
  logic signed [PROD_W-1:0]     prod_q;
  logic [H_W-1:0]               height_q;
  logic [CLS_W-1:0]             class_q;

  logic [31:0]                  mem_q [TABLE_ENTRIES];
  logic [31:0]                  rd_q;
  logic [AW-1:0]                raddr;
  logic [AW-1:0]                waddr;
  logic                         mem_we;

  logic signed [PX_W-1:0]       px, py;
  logic [AW-1:0]                base_d;
  logic [1:0]                   dk;
  logic signed [16:0]           ox, oy;
  logic signed [DOT_W-1:0]      dot;
  logic signed [T31_W-1:0]      t31;
  logic signed [PROD_W-1:0]     hrnd;
  logic signed [H_W-1:0]        h_sat;
  cls_e                         cls;
  logic                         can_emit;

  // Octave point, cell index and fraction.
  always_comb begin
    px     = PX_W'(x_q) <<< oct_q;
    py     = PX_W'(y_q) <<< oct_q;
    base_d = AW'(px[AW+15:16] * AW'(41) + py[AW+15:16] * AW'(43));
  end

  // Corner address: the x neighbor adds 41, the y neighbor adds 43.
  always_comb begin
    raddr = base_q;
    case (k_q[1:0])
      2'd1:    raddr = base_q + AW'(41);
      2'd2:    raddr = base_q + AW'(43);
      2'd3:    raddr = base_q + AW'(84);
      default: raddr = base_q;
    endcase
  end

  // Dot product of the corner read in the previous cycle.
  always_comb begin
    dk  = 2'(k_q - 3'd1);
    ox  = $signed({dk[0], tx_q});
    oy  = $signed({dk[1], ty_q});
    dot = DOT_W'($signed(rd_q[31:16]) * ox) + DOT_W'($signed(rd_q[15:0]) * oy);
  end

  // Normalization, saturation and classing.
  always_comb begin
    t31  = T31_W'((total_q + TOT_W'(32768)) >>> 16);
    hrnd = (prod_q + (PROD_W'(1) <<< 39)) >>> 40;
    if (hrnd > PROD_W'(32767))       h_sat = 16'sd32767;
    else if (hrnd < -PROD_W'(32768)) h_sat = -16'sd32768;
    else                             h_sat = H_W'(hrnd);
    if (h_sat <= thresh_i.water)      cls = CLS_WATER;
    else if (h_sat <= thresh_i.sand)  cls = CLS_SAND;
    else if (h_sat <= thresh_i.grass) cls = CLS_GRASS;
    else if (h_sat <= thresh_i.rock)  cls = CLS_ROCK;
    else                              cls = CLS_SNOW;
  end

  assign can_emit = !out_valid_q || out_o.ready;
  assign q_pop_o  = (state_q == S_IDLE) && q_valid_i;
  assign mem_we   = q_pop_o && (q_item_i.op == OP_LOAD) &&
                    (13'(q_item_i.entry_index) < 13'(TABLE_ENTRIES));
  assign waddr    = AW'(13'(q_item_i.entry_index));

  // Sequencer control.
  always_comb begin
    state_d     = state_q;
    oct_d       = oct_q;
    k_d         = k_q;
    out_valid_d = out_valid_q && !out_o.ready;
    case (state_q)
      S_IDLE: begin
        if (q_valid_i && q_item_i.op == OP_EVAL) begin
          state_d = S_CELL;
          oct_d   = '0;
        end
      end
      S_CELL: begin
        state_d = S_READ;
        k_d     = 3'd0;
      end
      S_READ: begin
        k_d = k_q + 3'd1;
        if (k_q == 3'd4) state_d = S_LERPX;
      end
      S_LERPX: state_d = S_LERPY;
      S_LERPY: state_d = S_ACCUM;
      S_ACCUM: begin
        if (oct_q == LAST_OCT) begin
          state_d = S_NORM;
        end else begin
          state_d = S_CELL;
          oct_d   = oct_q + OCT_W'(1);
        end
      end
      S_NORM: state_d = S_EMIT;
      S_EMIT: begin
        if (can_emit) begin
          state_d     = S_IDLE;
          out_valid_d = 1'b1;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      oct_q       <= '0;
      k_q         <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      oct_q       <= oct_d;
      k_q         <= k_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Datapath registers.
  always_ff @(posedge clk_i) begin
    case (state_q)
      S_IDLE: begin
        x_q     <= q_item_i.coord_x;
        y_q     <= q_item_i.coord_y;
        total_q <= '0;
      end
      S_CELL: begin
        tx_q   <= px[15:0];
        ty_q   <= py[15:0];
        t2x_q  <= 32'(px[15:0]) * 32'(px[15:0]);
        t2y_q  <= 32'(py[15:0]) * 32'(py[15:0]);
        base_q <= base_d;
      end
      S_READ: begin
        if (k_q == 3'd0) begin
          sx_q <= fade(t2x_q, tx_q);
          sy_q <= fade(t2y_q, ty_q);
        end else begin
          d_q[dk] <= dot;
        end
      end
      S_LERPX: begin
        i1_q <= lerp(d_q[0], d_q[1], sx_q);
        i2_q <= lerp(d_q[2], d_q[3], sx_q);
      end
      S_LERPY: n_q <= lerp(i1_q, i2_q, sy_q);
      S_ACCUM: total_q <= total_q + TOT_W'(n_q * $signed({1'b0, AMP_Q16[oct_q]}));
      S_NORM:  prod_q  <= PROD_W'(t31) * PROD_W'(RECIP_C);
      S_EMIT: begin
        if (can_emit) begin
          height_q <= h_sat;
          class_q  <= cls;
        end
      end
      default: ;
    endcase
  end

  // Gradient table: one write port, one registered read port.
  always_ff @(posedge clk_i) begin
    if (mem_we) mem_q[waddr] <= {q_item_i.grad_x, q_item_i.grad_y};
    rd_q <= mem_q[raddr];
  end

  assign out_o.valid         = out_valid_q;
  assign out_o.height        = height_q;
  assign out_o.terrain_class = class_q;
  assign status_o.busy       = (state_q != S_IDLE);
  assign status_o.octave     = oct_q;

endmodule

// ===== sv/fbm_gradient_noise_height.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fbm_gradient_noise_height
// Two-dimensional gradient noise summed over octaves, normalized to Q1.15
// and classed into terrain types.
// ----------------------------------------------------------------------------
//  Channel  Dir  Handshake    Payload
//  in_i     in   valid/ready  opcode, entry_index, grad_x, grad_y, coord_x, coord_y
//  out_o    out  valid/ready  height, terrain_class
//  cfg      in   cfg_we_i     cfg_idx_i, cfg_wdata_i
//
// A load item is written into the gradient table as the back end takes it. An
// evaluate item runs, for each octave, a cell step, reads of the four corners
// on the single read port of the gradient table, two lerp steps and an
// accumulate, then a normalize and an emit step. A two-entry queue lets the
// input keep accepting while the back end works or its result waits. Reset is
// asynchronous, active low; the gradient table is not cleared.
// ----------------------------------------------------------------------------
module fbm_gradient_noise_height #(
  parameter int unsigned OCTAVES       = 6
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  fbmgn_in_if.sink                         in_i,
  fbmgn_out_if.source                      out_o,
  input  logic                             cfg_we_i,
  input  logic [fbmgn_pkg::CFG_IW-1:0]     cfg_idx_i,
  input  logic [fbmgn_pkg::H_W-1:0]        cfg_wdata_i
);
  import fbmgn_pkg::*;

  thresh_t    thresh_q;
  logic       q_valid;
  item_t      q_item;
  logic       q_pop;
  bk_status_t bk_status;

  // Threshold registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thresh_q.water <= -16'sd3277;
      thresh_q.sand  <= 16'sd0;
      thresh_q.grass <= 16'sd9830;
      thresh_q.rock  <= 16'sd19661;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_WATER: thresh_q.water <= cfg_wdata_i;
        REG_SAND:  thresh_q.sand  <= cfg_wdata_i;
        REG_GRASS: thresh_q.grass <= cfg_wdata_i;
        REG_ROCK:  thresh_q.rock  <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  fbmgn_front u_front (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_i      (in_i),
    .q_valid_o (q_valid),
    .q_item_o  (q_item),
    .q_pop_i   (q_pop)
  );

  fbmgn_back #(
    .OCTAVES       (OCTAVES)
  ) u_back (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .q_valid_i (q_valid),
    .q_item_i  (q_item),
    .q_pop_o   (q_pop),
    .thresh_i  (thresh_q),
    .status_o  (bk_status),
    .out_o     (out_o)
  );

  // A result only appears at the end of an evaluation.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_o.valid) |-> $past(bk_status.busy))
    else $error("result raised without a running evaluation");

  // The octave counter stays within the configured octaves.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    bk_status.octave <= OCT_W'(OCTAVES - 1))
    else $error("octave counter out of range");

  // The back end only takes an item while idle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_pop |-> !bk_status.busy && q_valid)
    else $error("queue popped while busy or empty");

endmodule
